[hw/rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, codes and controller/datapath interface types for the
// k-way sorted merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int NUM_LISTS   = 8;
  localparam int LIST_DEPTH  = 16;
  localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;

  localparam int LIST_W = $clog2(NUM_LISTS);
  localparam int PTR_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  localparam int IDX_W    = 3;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic              capture;
    logic              append_do;
    logic              scan_rd;
    logic [LIST_W-1:0] scan_list;
    logic              pop_do;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_pop;
  } dp_stat_t;

endpackage

[hw/rtl/kwm_ram.sv]
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/kwm_dp.sv]
// ----------------------------------------------------------------------------
// kwm_dp
// Datapath: item register, per-list pointers, element store, head compare
// and result register.
// ----------------------------------------------------------------------------
module kwm_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  kwm_pkg::ctrl_cmd_t       cmd,
  output kwm_pkg::dp_stat_t        stat,
  input  logic                     in_pop,
  input  logic [kwm_pkg::IDX_W-1:0] in_idx,
  input  logic [kwm_pkg::VAL_W-1:0] in_val,
  output logic [kwm_pkg::STAT_W-1:0] out_status,
  output logic [kwm_pkg::VAL_W-1:0] out_value,
  output logic [kwm_pkg::IDX_W-1:0] out_source
);
  import kwm_pkg::*;

  logic [PTR_W-1:0]  wptr [NUM_LISTS];
  logic [PTR_W-1:0]  rptr [NUM_LISTS];

  logic              item_pop;
  logic [IDX_W-1:0]  item_idx;
  logic [VAL_W-1:0]  item_val;

  logic [LIST_W-1:0] sel_list;
  logic [PTR_W-1:0]  wptr_sel;
  logic [PTR_W-1:0]  rptr_sel;
  logic              sel_live;
  logic              full;
  logic              store_wr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;

  logic              rd_live;
  logic [LIST_W-1:0] rd_list;
  logic [PTR_W-1:0]  rd_rptr;
  logic [PTR_W-1:0]  rd_wptr;
  logic              take;

  logic              found;
  logic [VAL_W-1:0]  best_val;
  logic [LIST_W-1:0] best_list;
  logic [PTR_W-1:0]  best_rptr;
  logic [PTR_W-1:0]  best_wptr;
  logic [PTR_W-1:0]  rptr_next;

  assign stat.item_pop = item_pop;

  assign sel_list = cmd.scan_rd ? cmd.scan_list : LIST_W'(item_idx);
  assign wptr_sel = wptr[sel_list];
  assign rptr_sel = rptr[sel_list];
  assign sel_live = rptr_sel < wptr_sel;

  assign full     = (32'(item_idx) >= NUM_LISTS) || (wptr_sel >= PTR_W'(LIST_DEPTH));
  assign store_wr = cmd.append_do && !full;
  assign wr_addr  = ADDR_W'(32'(sel_list) * LIST_DEPTH + 32'(wptr_sel));
  assign rd_addr  = ADDR_W'(32'(sel_list) * LIST_DEPTH + 32'(rptr_sel));

  assign take      = rd_live && (!found || ($signed(rd_data) < $signed(best_val)));
  assign rptr_next = best_rptr + PTR_W'(1);

  kwm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (wr_addr),
    .wr_data (item_val),
    .rd_en   (cmd.scan_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        wptr[i] <= '0;
        rptr[i] <= '0;
      end
      rd_live  <= 1'b0;
      found    <= 1'b0;
      item_pop <= 1'b0;
    end else begin
      rd_live <= cmd.scan_rd && sel_live;
      if (cmd.capture) begin
        item_pop <= in_pop;
        found    <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (store_wr) begin
        wptr[sel_list] <= wptr_sel + PTR_W'(1);
      end
      if (cmd.pop_do && found) begin
        if (rptr_next >= best_wptr) begin
          rptr[best_list] <= '0;
          wptr[best_list] <= '0;
        end else begin
          rptr[best_list] <= rptr_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_list <= sel_list;
    rd_rptr <= rptr_sel;
    rd_wptr <= wptr_sel;
    if (cmd.capture) begin
      item_idx <= in_idx;
      item_val <= in_val;
    end
    if (take) begin
      best_val  <= rd_data;
      best_list <= rd_list;
      best_rptr <= rd_rptr;
      best_wptr <= rd_wptr;
    end
    if (cmd.append_do) begin
      out_status <= full ? STATUS_FULL : STATUS_OK;
      out_value  <= '0;
      out_source <= '0;
    end else if (cmd.pop_do) begin
      out_status <= found ? STATUS_OK : STATUS_EMPTY;
      out_value  <= found ? best_val : '0;
      out_source <= found ? IDX_W'(best_list) : '0;
    end
  end

endmodule

[hw/rtl/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl
// Controller: input/output handshakes and the append/scan/pop sequence.
// ----------------------------------------------------------------------------
module kwm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output kwm_pkg::ctrl_cmd_t cmd,
  input  kwm_pkg::dp_stat_t  stat
);
  import kwm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [LIST_W-1:0] cnt;
  logic              out_free;
  logic              last_list;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign last_list = (cnt == LIST_W'(NUM_LISTS - 1));

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.scan_list = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.item_pop) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          cmd.append_do = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (last_list) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_POP;
      end
      S_POP: begin
        if (out_free) begin
          cmd.pop_do = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        cnt <= last_list ? '0 : cnt + LIST_W'(1);
      end
      if (cmd.append_do || cmd.pop_do) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.append_do, cmd.scan_rd, cmd.pop_do}))
    else $error("kwm_ctrl: overlapping datapath commands");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && last_list) |=> (state == S_DRAIN))
    else $error("kwm_ctrl: scan did not end after last list");

  a_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.append_do || cmd.pop_do) |=> (out_valid && state == S_IDLE))
    else $error("kwm_ctrl: result not presented");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (cmd.append_do || cmd.pop_do) |-> (!out_valid || out_ready))
    else $error("kwm_ctrl: pending result overwritten");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && stat.item_pop) |=> (state == S_SCAN && cnt == '0))
    else $error("kwm_ctrl: scan did not start at list zero");

endmodule

[hw/rtl/k_way_sorted_merge_top.sv]
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top
// Merges up to NUM_LISTS ascending lists into one ascending stream.
//
//   channel  dir  tdata (low bit up)                 tuser
//   s_axis   in   list_index[2:0], value[34:3]       command (0 append, 1 pop)
//   m_axis   out  merged_value[31:0], source[34:32]  status[1:0]
//
// Append: capture, then store write with the result.
// Pop: capture, decode, one head read and compare per list through the
// single store read port, drain, pointer update.
// One transaction in work at a time; the next is taken as soon as the
// result sits in the output register.
// Synchronous reset clears all list pointers; the store needs no clearing.
// A stalled output holds back only the finishing step of the next command.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [kwm_pkg::S_DATA_W-1:0] s_tdata,  // list_index, value, zero pad
  input  logic                        s_tuser,  // command
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [kwm_pkg::M_DATA_W-1:0] m_tdata,  // merged_value, source_list, pad
  output logic [kwm_pkg::STAT_W-1:0]  m_tuser   // status
);
  import kwm_pkg::*;

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  logic [VAL_W-1:0] out_value;
  logic [IDX_W-1:0] out_source;

  kwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  kwm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_pop     (s_tuser),
    .in_idx     (s_tdata[IDX_W-1:0]),
    .in_val     (s_tdata[IDX_W+VAL_W-1:IDX_W]),
    .out_status (m_tuser),
    .out_value  (out_value),
    .out_source (out_source)
  );

  assign m_tdata = {{(M_DATA_W - VAL_W - IDX_W){1'b0}}, out_source, out_value};

endmodule

[dv/k_way_sorted_merge_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top_tb
// Self-checking bench for the k-way sorted merge. Append and pop transactions
// go in on the slave stream. A scoreboard keeps its own copy of every list and
// of its head and tail counts, predicts each result and compares it field by
// field on the master stream. Both sides idle at random. The receiver holds
// off once for a long stretch, and the sender drains the block between phases.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_top_tb;
  import kwm_pkg::*;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam int RANDOM_ITEMS = 1025;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  merged_value;
    logic [IDX_W-1:0]  source_list;
  } merge_result_t;

  class merge_scoreboard;
    logic [VAL_W-1:0] store [NUM_LISTS][LIST_DEPTH];
    logic [PTR_W-1:0] tail_count [NUM_LISTS];
    logic [PTR_W-1:0] head_count [NUM_LISTS];
    merge_result_t    expected [$];
    int               errors;

    function new();
      for (int i = 0; i < NUM_LISTS; i++) begin
        tail_count[i] = '0;
        head_count[i] = '0;
      end
      errors = 0;
    endfunction

    function void note_command(logic cmd, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
      merge_result_t r;
      bit            found;
      int            best;
      r     = '0;
      found = 0;
      best  = 0;
      if (cmd == CMD_APPEND) begin
        if (idx >= NUM_LISTS || tail_count[idx] >= LIST_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          store[idx][tail_count[idx]] = val;
          tail_count[idx] = tail_count[idx] + 1'b1;
        end
      end else begin
        for (int i = 0; i < NUM_LISTS; i++) begin
          if (head_count[i] < tail_count[i]) begin
            if (!found ||
                $signed(store[i][head_count[i]]) < $signed(store[best][head_count[best]])) begin
              found = 1;
              best  = i;
            end
          end
        end
        if (!found) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.status       = STATUS_OK;
          r.merged_value = store[best][head_count[best]];
          r.source_list  = best[IDX_W-1:0];
          head_count[best] = head_count[best] + 1'b1;
          if (head_count[best] >= tail_count[best]) begin
            head_count[best] = '0;
            tail_count[best] = '0;
          end
        end
      end
      expected = {expected, r};
    endfunction

    function void check_result(merge_result_t got);
      merge_result_t exp;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d value %0d list %0d",
                 $time, got.status, $signed(got.merged_value), got.source_list);
        return;
      end
      exp = expected.pop_front();
      if (got.status !== exp.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, got %0d", $time, exp.status, got.status);
      end
      if (got.merged_value !== exp.merged_value) begin
        errors++;
        $display("%0t: merged_value mismatch, expected %0d, got %0d", $time,
                 $signed(exp.merged_value), $signed(got.merged_value));
      end
      if (got.source_list !== exp.source_list) begin
        errors++;
        $display("%0t: source_list mismatch, expected %0d, got %0d", $time,
                 exp.source_list, got.source_list);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]   m_tuser;

  merge_scoreboard sb = new();
  bit              hold_req = 0;
  int              idle_cycles = 0;
  logic [VAL_W-1:0] list_tail [NUM_LISTS];

  k_way_sorted_merge_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        sb.check_result({m_tuser, m_tdata[VAL_W-1:0], m_tdata[VAL_W+IDX_W-1:VAL_W]});
      end
      if (s_tvalid && s_tready) begin
        sb.note_command(s_tuser, s_tdata[IDX_W-1:0], s_tdata[IDX_W+VAL_W-1:IDX_W]);
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver back-pressure
  initial begin
    int r;
    m_tready = 1'b0;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 11) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 17) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 19) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end else begin
          m_tready <= 1'b1;
          repeat ($urandom_range(50, 120)) @(posedge clk);
        end
      end
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 19);
    if (calm || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_command(input logic cmd, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val, input int gap);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(S_DATA_W - VAL_W - IDX_W){1'b0}}, val, idx};
    do @(posedge clk); while (!s_tready);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_append(input bit calm);
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   val;
    logic [VAL_W-1:0]   step;
    logic signed [VAL_W:0] sum;
    idx = IDX_W'($urandom_range(0, NUM_LISTS - 1));
    if ($urandom_range(0, 9) < 8) begin
      // ascending run per list, restarting low once the top is reached
      step = $urandom_range(0, 2000);
      sum  = $signed({list_tail[idx][VAL_W-1], list_tail[idx]}) + $signed({1'b0, step});
      if (sum > 33'sh0_7FFF_FFFF) val = $urandom | 32'h8000_0000;
      else val = sum[VAL_W-1:0];
      list_tail[idx] = val;
    end else begin
      val = $urandom;
    end
    send_command(CMD_APPEND, idx, val, pick_gap(calm));
  endtask

  initial begin
    int  pop_pct;
    bit  calm;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_APPEND;
    for (int i = 0; i < NUM_LISTS; i++) list_tail[i] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pop with nothing stored, extremes, a tie, then a list filled past depth
    send_command(CMD_POP, 3'd7, 32'hFFFF_FFFF, 0);
    send_command(CMD_APPEND, 3'd7, 32'h8000_0000, 0);
    send_command(CMD_APPEND, 3'd0, 32'h7FFF_FFFF, 1);
    send_command(CMD_APPEND, 3'd2, 32'h0000_0005, 0);
    send_command(CMD_APPEND, 3'd5, 32'h0000_0005, 2);
    repeat (4) send_command(CMD_POP, 3'd0, 32'h0, 0);
    for (int i = 0; i < LIST_DEPTH + 1; i++) begin
      send_command(CMD_APPEND, 3'd3, 32'hFFFF_FFF0 + i, pick_gap(0));
    end
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 60) % 4)
        0: begin pop_pct = 40; calm = 0; end
        1: begin pop_pct = 15; calm = 0; end
        2: begin pop_pct = 70; calm = 0; end
        default: begin pop_pct = 45; calm = 1; end
      endcase
      if (n == 130) hold_req = 1;
      if (n == 600) wait_drained();
      if ($urandom_range(0, 99) < pop_pct) begin
        send_command(CMD_POP, IDX_W'($urandom_range(0, NUM_LISTS - 1)), $urandom,
                     pick_gap(calm));
      end else begin
        send_random_append(calm);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
